### sv/tcrb_pkg.sv
// Shared types and constants for the text console row buffer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package tcrb_pkg;

	// Item kinds carried in the input tuser field.
	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_SOFT_NL = 2'd1,
		OP_ROW     = 2'd2,
		OP_CHAR    = 2'd3
	} opcode_t;

	// Default geometry of the console.
	localparam int DEF_ROW_COUNT    = 32;
	localparam int DEF_COLUMN_COUNT = 64;

	// Fixed field widths of the streaming items.
	localparam int CHAR_W     = 8;
	localparam int RIDX_W     = 5;
	localparam int CADDR_W    = 11;
	localparam int OFS_W      = 12;
	localparam int COUNT_W    = 6;

	// Hard newline character.
	localparam logic [CHAR_W-1:0] LINE_FEED = 8'd10;

endpackage

### sv/text_console_row_buffer.sv
// Text console row buffer: character store, row table and cursor control.
// Depends on tcrb_pkg for item kinds, field widths and default geometry.
`timescale 1ns / 1ps

// Usage:
// Items enter on the s_ channel: tuser holds the kind (put character, soft
// newline, row query, character read), tdata the character, the row index
// and the store address. Every item gives exactly one result item on the m_
// channel, with the row descriptor, the shown row count, the read character
// and, in tuser, the dropped flag for a put character.
// The mode register is written on the cfg_ channel; the user must write it
// only while no item is in flight, which the block does not enforce. A write
// restarts the cursor but keeps rows and characters. A result is valid in the
// cycle after its item is accepted, set by the registered read of the row
// table and character store memories. Throughput is one item per cycle: the
// cursor update and the memory writes finish in the accepting cycle, so the
// next item sees them at once. When the receiver stalls, the result stays in
// the output stage and one more item is not taken until that result leaves.
// Reset clears the cursor state, the mode and the row table valid bits, so
// every row reads as empty; the character store is not cleared.
module text_console_row_buffer
	import tcrb_pkg::*;
#(
	parameter int ROW_COUNT    = DEF_ROW_COUNT,
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input items.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// char_code [7:0], row_index [12:8], char_address [23:13]
	input  logic [23:0]          s_tdata,
	// opcode [1:0]
	input  logic [1:0]           s_tuser,
	// Result items.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// row_start [11:0], row_end [23:12], row_count [29:24], char_data [37:30],
	// zero fill [39:38]
	output logic [39:0]          m_tdata,
	// dropped [0]
	output logic [0:0]           m_tuser,
	// Mode register write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);

	localparam int STORE_DEPTH = ROW_COUNT * COLUMN_COUNT;
	localparam int PTR_W       = $clog2(STORE_DEPTH + 1);
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(ROW_COUNT + 1);
	localparam int ROW_AW      = $clog2(ROW_COUNT);
	localparam int SUM_W       = ((CNT_W > RIDX_W) ? CNT_W : RIDX_W) + 1;
	localparam int ENTRY_W     = 2 * PTR_W;

	localparam logic [PTR_W-1:0] COLS_P = PTR_W'(COLUMN_COUNT);
	localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROW_COUNT);
	localparam logic [SUM_W-1:0] ROWS_S = SUM_W'(ROW_COUNT);
	localparam logic [31:0]      DEPTH_L = 32'(STORE_DEPTH);

	// Unpacked input fields.
	opcode_t             opcode;
	logic [CHAR_W-1:0]   char_code;
	logic [RIDX_W-1:0]   row_index;
	logic [CADDR_W-1:0]  char_address;

	assign opcode       = opcode_t'(s_tuser);
	assign char_code    = s_tdata[7:0];
	assign row_index    = s_tdata[12:8];
	assign char_address = s_tdata[23:13];

	// Cursor state.
	logic               wrap_q;
	logic [PTR_W-1:0]   cursor_q;
	logic [PTR_W-1:0]   ors_q;
	logic [PTR_W-1:0]   lim_q;
	logic [CNT_W-1:0]   cur_row_q;
	logic [ROW_COUNT-1:0] row_valid_q;

	// Memories.
	logic [CHAR_W-1:0]  char_mem [STORE_DEPTH];
	logic [ENTRY_W-1:0] row_mem [ROW_COUNT];

	// Output stage.
	logic               valid_s1;
	logic               row_hit_s1;
	logic               fwd_s1;
	logic [ENTRY_W-1:0] fwd_data_s1;
	logic               slot_valid_s1;
	logic               char_hit_s1;
	logic               drop_s1;
	logic [COUNT_W-1:0] count_s1;
	logic [ENTRY_W-1:0] row_rd_s1;
	logic [CHAR_W-1:0]  char_rd_s1;

	logic s_accept;
	logic cfg_accept;

	assign s_tready   = !valid_s1 || m_tready;
	assign s_accept   = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	// Next-state and access signals.
	logic               part;
	logic               row_ok;
	logic [CNT_W-1:0]   cr_inc;
	logic               inc_ok;
	logic [PTR_W-1:0]   cl_cursor, cl_ors, cl_lim;
	logic [CNT_W-1:0]   cl_row;
	logic [PTR_W-1:0]   nx_cursor, nx_ors, nx_lim;
	logic [CNT_W-1:0]   nx_row;
	logic               nx_part;
	logic [CNT_W-1:0]   nx_pos;
	logic               tab_we;
	logic               char_we;
	logic [AW-1:0]      char_wa;
	logic               drop;
	logic [CNT_W-1:0]   q_pos;
	logic [CNT_W-1:0]   q_count;
	logic [SUM_W-1:0]   ridx_ext, pos_ext, count_ext, slot_sum, slot_full;
	logic               q_hit;
	logic [ROW_AW-1:0]  slot;
	logic [ROW_AW-1:0]  wr_row;
	logic               fwd;
	logic               char_hit;
	logic [AW-1:0]      char_ra;

	// Closing the open row, shared by line feed, soft newline and wrap-on-full.
	always_comb begin
		part   = cursor_q != ors_q;
		row_ok = cur_row_q < ROWS_C;
		cr_inc = cur_row_q + CNT_W'(1);
		inc_ok = cr_inc < ROWS_C;
		if (!wrap_q) begin
			cl_cursor = cursor_q;
			cl_ors    = cursor_q;
			cl_lim    = inc_ok ? cursor_q + COLS_P : cursor_q;
			cl_row    = cr_inc;
		end else if (inc_ok) begin
			cl_ors    = ors_q + COLS_P;
			cl_lim    = lim_q + COLS_P;
			cl_row    = cr_inc;
			cl_cursor = cl_ors;
		end else begin
			cl_ors    = '0;
			cl_lim    = COLS_P;
			cl_row    = '0;
			cl_cursor = '0;
		end
	end

	// Per-item state update and memory writes.
	always_comb begin
		nx_cursor = cursor_q;
		nx_ors    = ors_q;
		nx_lim    = lim_q;
		nx_row    = cur_row_q;
		tab_we    = 1'b0;
		char_we   = 1'b0;
		char_wa   = AW'(cursor_q);
		drop      = 1'b0;
		case (opcode)
			OP_PUT: begin
				if (char_code == LINE_FEED) begin
					if (row_ok) begin
						tab_we    = 1'b1;
						nx_cursor = cl_cursor;
						nx_ors    = cl_ors;
						nx_lim    = cl_lim;
						nx_row    = cl_row;
					end else begin
						drop = 1'b1;
					end
				end else if (cursor_q < lim_q) begin
					char_we   = 1'b1;
					nx_cursor = cursor_q + PTR_W'(1);
				end else if (row_ok) begin
					// Full row: close it, then place the character on the next row, or drop it if none is left.
					tab_we    = 1'b1;
					nx_cursor = cl_cursor;
					nx_ors    = cl_ors;
					nx_lim    = cl_lim;
					nx_row    = cl_row;
					if (wrap_q || inc_ok) begin
						char_we   = 1'b1;
						char_wa   = AW'(cl_cursor);
						nx_cursor = cl_cursor + PTR_W'(1);
					end else begin
						drop = 1'b1;
					end
				end else begin
					drop = 1'b1;
				end
			end
			OP_SOFT_NL: begin
				if (part) begin
					tab_we    = 1'b1;
					nx_cursor = cl_cursor;
					nx_ors    = cl_ors;
					nx_lim    = cl_lim;
					nx_row    = cl_row;
				end
			end
			OP_ROW: begin
				// A query records a non-empty open row in its slot while the current row is in range.
				tab_we = part && row_ok;
			end
			default: begin
			end
		endcase
		nx_part = nx_cursor != nx_ors;
		nx_pos  = nx_row + CNT_W'(nx_part);
	end

	// Row query: slot selection and forwarding of the query's own record.
	always_comb begin
		q_pos     = cur_row_q + CNT_W'(part);
		q_count   = wrap_q ? ROWS_C : q_pos;
		ridx_ext  = SUM_W'(row_index);
		pos_ext   = SUM_W'(q_pos);
		count_ext = SUM_W'(q_count);
		q_hit     = ridx_ext < count_ext;
		slot_sum  = ridx_ext + pos_ext;
		if (wrap_q) begin
			slot_full = (slot_sum >= ROWS_S) ? slot_sum - ROWS_S : slot_sum;
		end else begin
			slot_full = ridx_ext;
		end
		slot     = ROW_AW'(slot_full);
		wr_row   = ROW_AW'(cur_row_q);
		fwd      = tab_we && (slot == wr_row);
		char_hit = 32'(char_address) < DEPTH_L;
		char_ra  = AW'(char_address);
	end

	// Cursor registers; a mode write restarts the cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q    <= 1'b0;
			cursor_q  <= '0;
			ors_q     <= '0;
			lim_q     <= COLS_P;
			cur_row_q <= '0;
		end else if (cfg_accept) begin
			wrap_q    <= cfg_data;
			cursor_q  <= '0;
			ors_q     <= '0;
			lim_q     <= COLS_P;
			cur_row_q <= '0;
		end else if (s_accept) begin
			cursor_q  <= nx_cursor;
			ors_q     <= nx_ors;
			lim_q     <= nx_lim;
			cur_row_q <= nx_row;
		end
	end

	// Row table valid bits: an entry never written reads as an empty row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (s_accept && tab_we) begin
			row_valid_q[wr_row] <= 1'b1;
		end
	end

	// Row table memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (s_accept && tab_we) begin
			row_mem[wr_row] <= {ors_q, cursor_q};
		end
		if (s_accept) begin
			row_rd_s1 <= row_mem[slot];
		end
	end

	// Character store memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (s_accept && char_we) begin
			char_mem[char_wa] <= char_code;
		end
		if (s_accept) begin
			char_rd_s1 <= char_mem[char_ra];
		end
	end

	// Output stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			row_hit_s1    <= (opcode == OP_ROW) && q_hit;
			fwd_s1        <= fwd;
			fwd_data_s1   <= {ors_q, cursor_q};
			slot_valid_s1 <= row_valid_q[slot];
			char_hit_s1   <= (opcode == OP_CHAR) && char_hit;
			drop_s1       <= drop;
			count_s1      <= COUNT_W'(wrap_q ? ROWS_C : nx_pos);
		end
	end

	// Result assembly.
	logic [ENTRY_W-1:0] row_word;
	logic [OFS_W-1:0]   row_start;
	logic [OFS_W-1:0]   row_end;
	logic [CHAR_W-1:0]  char_data;

	always_comb begin
		if (fwd_s1) begin
			row_word = fwd_data_s1;
		end else if (slot_valid_s1) begin
			row_word = row_rd_s1;
		end else begin
			row_word = '0;
		end
		row_start = row_hit_s1 ? OFS_W'(row_word[ENTRY_W-1:PTR_W]) : '0;
		row_end   = row_hit_s1 ? OFS_W'(row_word[PTR_W-1:0]) : '0;
		char_data = char_hit_s1 ? char_rd_s1 : '0;
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {2'b00, char_data, count_s1, row_end, row_start};
	assign m_tuser  = drop_s1;

	// The cursor never passes the limit of the open row.
	a_cursor_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= lim_q)
		else $error("cursor beyond open row limit");

	// The open row never starts after the cursor.
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		ors_q <= cursor_q)
		else $error("open row start after cursor");

	// In wrap mode the current row slot is always a real slot.
	a_wrap_row: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |-> (cur_row_q < ROWS_C))
		else $error("current row out of range in wrap mode");

	// A stalled result keeps its dropped flag until taken.
	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !m_tready) |=> $stable(drop_s1))
		else $error("dropped flag changed under stall");

endmodule
